@@ hdl/qrv_pkg.sv @@
// ----------------------------------------------------------------------------
// qrv_pkg
// Word types, fixed-point widths and pipeline constants for the quaternion
// vector rotation block.
// ----------------------------------------------------------------------------
package qrv_pkg;

    // field widths
    localparam int Q_W      = 32;   // quaternion component, Q2.30
    localparam int V_W      = 32;   // vector component, Q16.16
    localparam int ROUND_SH = 30;   // drop the Q2.30 fraction

    // first product q * (0, p)
    localparam int PROD1_W  = 64;   // Q2.30 x Q16.16
    localparam int SUM1_W   = 67;   // sum of three products plus sign headroom
    localparam int R_W      = 35;   // rounded intermediate quaternion, Q.16

    // second product r * q
    localparam int PROD2_W  = 67;   // Q.16 x Q2.30
    localparam int SUM2_W   = 69;   // sum of four products plus sign headroom
    localparam int O_W      = 39;   // rounded result before saturation

    // round half up bias
    localparam logic signed [SUM1_W-1:0] RND1 = SUM1_W'(1) <<< (ROUND_SH - 1);
    localparam logic signed [SUM2_W-1:0] RND2 = SUM2_W'(1) <<< (ROUND_SH - 1);

    // pipeline stages
    localparam int NUM_STAGES = 5;
    localparam int ST_PROD1   = 0;  // first products
    localparam int ST_RVEC    = 1;  // intermediate quaternion r
    localparam int ST_PROD2   = 2;  // second products
    localparam int ST_OPRE    = 3;  // rounded outputs
    localparam int ST_OUT     = 4;  // saturated output word

    // direction codes
    localparam logic OP_FWD = 1'b0;
    localparam logic OP_INV = 1'b1;

    typedef struct packed {
        logic                  op;
        logic signed [Q_W-1:0] quat_w;
        logic signed [Q_W-1:0] quat_x;
        logic signed [Q_W-1:0] quat_y;
        logic signed [Q_W-1:0] quat_z;
        logic signed [V_W-1:0] vec_x;
        logic signed [V_W-1:0] vec_y;
        logic signed [V_W-1:0] vec_z;
    } req_t;

    typedef struct packed {
        logic signed [V_W-1:0] out_x;
        logic signed [V_W-1:0] out_y;
        logic signed [V_W-1:0] out_z;
        logic                  overflow;
    } rsp_t;

    // per-stage load enables and occupancy
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
        logic [NUM_STAGES-1:0] valid;
    } ctl_t;

endpackage

@@ hdl/qrv_pipe_ctl.sv @@
// ----------------------------------------------------------------------------
// qrv_pipe_ctl
// Valid bits and load enables for the rotation pipeline. A stage loads when
// it is empty or when the stage after it loads, so bubbles close up and a
// stall at the output holds every full stage in place.
// ----------------------------------------------------------------------------
module qrv_pipe_ctl
    import qrv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  logic rsp_ready,
    output ctl_t ctl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] en;

    // enable chain, from the output back to the input
    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || rsp_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    // valid bits follow the data
    always_comb
    begin
        valid_next[0] = en[0] ? req_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign req_ready = en[0];
    assign ctl.en    = en;
    assign ctl.valid = valid_reg;

    // a stalled output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[NUM_STAGES-1] && !rsp_ready) |=> valid_reg[NUM_STAGES-1])
        else $error("output word dropped while stalled");

    // a full pipeline with a stalled output takes no new word
    a_full_block: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg && !rsp_ready) |-> !req_ready)
        else $error("word taken into a full pipeline");

    // an accepted word lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> valid_reg[0])
        else $error("accepted word lost at the first stage");

    // words in flight change only by what enters and what leaves
    a_conserve: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(valid_reg) ==
            $past($countones(valid_reg)) + $past(req_valid && req_ready)
            - $past(valid_reg[NUM_STAGES-1] && rsp_ready)))
        else $error("word count in the pipeline is off");

endmodule

@@ hdl/quat_rotate_vector.sv @@
// ----------------------------------------------------------------------------
// quat_rotate_vector
// Rotates a Q16.16 vector by a Q2.30 quaternion or by its inverse, with
// round half up after each Hamilton product and saturation at the output.
// ----------------------------------------------------------------------------
// The block takes one word per cycle and returns each result through a
// five-stage pipeline: first products, intermediate quaternion r, second
// products, rounded sums, saturation. The pipeline depth is set by the two
// multiply and sum passes; throughput stays at one word per cycle as long
// as rsp_ready is high. req_ready depends on rsp_ready through the stage
// enable chain, and a stall holds every stage without loss.
// The quaternion is used as given, so a non-unit quaternion scales the result
// by its squared length; overflow flags any saturated component.
module quat_rotate_vector
    import qrv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    ctl_t ctl;

    qrv_pipe_ctl u_ctl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_ready (rsp_ready),
        .ctl       (ctl)
    );

    // ------------------------------------------------------------------
    // stage 1: products of q and p
    // ------------------------------------------------------------------
    logic signed [PROD1_W-1:0] p_xpx_reg, p_ypy_reg, p_zpz_reg;
    logic signed [PROD1_W-1:0] p_wpx_reg, p_ypz_reg, p_zpy_reg;
    logic signed [PROD1_W-1:0] p_wpy_reg, p_zpx_reg, p_xpz_reg;
    logic signed [PROD1_W-1:0] p_wpz_reg, p_xpy_reg, p_ypx_reg;
    logic signed [PROD1_W-1:0] p_xpx_next, p_ypy_next, p_zpz_next;
    logic signed [PROD1_W-1:0] p_wpx_next, p_ypz_next, p_zpy_next;
    logic signed [PROD1_W-1:0] p_wpy_next, p_zpx_next, p_xpz_next;
    logic signed [PROD1_W-1:0] p_wpz_next, p_xpy_next, p_ypx_next;
    logic signed [Q_W-1:0]     q1_w_reg, q1_x_reg, q1_y_reg, q1_z_reg;
    logic                      op1_reg;

    always_comb
    begin
        p_xpx_next = PROD1_W'(req.quat_x) * PROD1_W'(req.vec_x);
        p_ypy_next = PROD1_W'(req.quat_y) * PROD1_W'(req.vec_y);
        p_zpz_next = PROD1_W'(req.quat_z) * PROD1_W'(req.vec_z);
        p_wpx_next = PROD1_W'(req.quat_w) * PROD1_W'(req.vec_x);
        p_ypz_next = PROD1_W'(req.quat_y) * PROD1_W'(req.vec_z);
        p_zpy_next = PROD1_W'(req.quat_z) * PROD1_W'(req.vec_y);
        p_wpy_next = PROD1_W'(req.quat_w) * PROD1_W'(req.vec_y);
        p_zpx_next = PROD1_W'(req.quat_z) * PROD1_W'(req.vec_x);
        p_xpz_next = PROD1_W'(req.quat_x) * PROD1_W'(req.vec_z);
        p_wpz_next = PROD1_W'(req.quat_w) * PROD1_W'(req.vec_z);
        p_xpy_next = PROD1_W'(req.quat_x) * PROD1_W'(req.vec_y);
        p_ypx_next = PROD1_W'(req.quat_y) * PROD1_W'(req.vec_x);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_PROD1])
        begin
            p_xpx_reg <= p_xpx_next;
            p_ypy_reg <= p_ypy_next;
            p_zpz_reg <= p_zpz_next;
            p_wpx_reg <= p_wpx_next;
            p_ypz_reg <= p_ypz_next;
            p_zpy_reg <= p_zpy_next;
            p_wpy_reg <= p_wpy_next;
            p_zpx_reg <= p_zpx_next;
            p_xpz_reg <= p_xpz_next;
            p_wpz_reg <= p_wpz_next;
            p_xpy_reg <= p_xpy_next;
            p_ypx_reg <= p_ypx_next;
            q1_w_reg  <= req.quat_w;
            q1_x_reg  <= req.quat_x;
            q1_y_reg  <= req.quat_y;
            q1_z_reg  <= req.quat_z;
            op1_reg   <= req.op;
        end
    end

    // ------------------------------------------------------------------
    // stage 2: r = q * (0, p) or conj(q) * (0, p), rounded to Q.16
    // ------------------------------------------------------------------
    logic signed [SUM1_W-1:0] dot1, crx1, cry1, crz1;
    logic signed [SUM1_W-1:0] srw, srx, sry, srz;
    logic signed [R_W-1:0]    r_w_reg, r_x_reg, r_y_reg, r_z_reg;
    logic signed [R_W-1:0]    r_w_next, r_x_next, r_y_next, r_z_next;
    logic signed [Q_W-1:0]    q2_w_reg, q2_x_reg, q2_y_reg, q2_z_reg;
    logic                     op2_reg;

    always_comb
    begin
        dot1 = SUM1_W'(p_xpx_reg) + SUM1_W'(p_ypy_reg) + SUM1_W'(p_zpz_reg);
        crx1 = SUM1_W'(p_ypz_reg) - SUM1_W'(p_zpy_reg);
        cry1 = SUM1_W'(p_zpx_reg) - SUM1_W'(p_xpz_reg);
        crz1 = SUM1_W'(p_xpy_reg) - SUM1_W'(p_ypx_reg);
        // the inverse flips the sign of every vector-part term
        srw  = (op1_reg == OP_INV) ? dot1 : -dot1;
        srx  = SUM1_W'(p_wpx_reg) + ((op1_reg == OP_INV) ? -crx1 : crx1);
        sry  = SUM1_W'(p_wpy_reg) + ((op1_reg == OP_INV) ? -cry1 : cry1);
        srz  = SUM1_W'(p_wpz_reg) + ((op1_reg == OP_INV) ? -crz1 : crz1);
        r_w_next = R_W'((srw + RND1) >>> ROUND_SH);
        r_x_next = R_W'((srx + RND1) >>> ROUND_SH);
        r_y_next = R_W'((sry + RND1) >>> ROUND_SH);
        r_z_next = R_W'((srz + RND1) >>> ROUND_SH);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_RVEC])
        begin
            r_w_reg  <= r_w_next;
            r_x_reg  <= r_x_next;
            r_y_reg  <= r_y_next;
            r_z_reg  <= r_z_next;
            q2_w_reg <= q1_w_reg;
            q2_x_reg <= q1_x_reg;
            q2_y_reg <= q1_y_reg;
            q2_z_reg <= q1_z_reg;
            op2_reg  <= op1_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: products of r and q
    // ------------------------------------------------------------------
    logic signed [PROD2_W-1:0] m_rxw_reg, m_rwx_reg, m_ryz_reg, m_rzy_reg;
    logic signed [PROD2_W-1:0] m_ryw_reg, m_rwy_reg, m_rzx_reg, m_rxz_reg;
    logic signed [PROD2_W-1:0] m_rzw_reg, m_rwz_reg, m_rxy_reg, m_ryx_reg;
    logic signed [PROD2_W-1:0] m_rxw_next, m_rwx_next, m_ryz_next, m_rzy_next;
    logic signed [PROD2_W-1:0] m_ryw_next, m_rwy_next, m_rzx_next, m_rxz_next;
    logic signed [PROD2_W-1:0] m_rzw_next, m_rwz_next, m_rxy_next, m_ryx_next;
    logic                      op3_reg;

    always_comb
    begin
        m_rxw_next = PROD2_W'(r_x_reg) * PROD2_W'(q2_w_reg);
        m_rwx_next = PROD2_W'(r_w_reg) * PROD2_W'(q2_x_reg);
        m_ryz_next = PROD2_W'(r_y_reg) * PROD2_W'(q2_z_reg);
        m_rzy_next = PROD2_W'(r_z_reg) * PROD2_W'(q2_y_reg);
        m_ryw_next = PROD2_W'(r_y_reg) * PROD2_W'(q2_w_reg);
        m_rwy_next = PROD2_W'(r_w_reg) * PROD2_W'(q2_y_reg);
        m_rzx_next = PROD2_W'(r_z_reg) * PROD2_W'(q2_x_reg);
        m_rxz_next = PROD2_W'(r_x_reg) * PROD2_W'(q2_z_reg);
        m_rzw_next = PROD2_W'(r_z_reg) * PROD2_W'(q2_w_reg);
        m_rwz_next = PROD2_W'(r_w_reg) * PROD2_W'(q2_z_reg);
        m_rxy_next = PROD2_W'(r_x_reg) * PROD2_W'(q2_y_reg);
        m_ryx_next = PROD2_W'(r_y_reg) * PROD2_W'(q2_x_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_PROD2])
        begin
            m_rxw_reg <= m_rxw_next;
            m_rwx_reg <= m_rwx_next;
            m_ryz_reg <= m_ryz_next;
            m_rzy_reg <= m_rzy_next;
            m_ryw_reg <= m_ryw_next;
            m_rwy_reg <= m_rwy_next;
            m_rzx_reg <= m_rzx_next;
            m_rxz_reg <= m_rxz_next;
            m_rzw_reg <= m_rzw_next;
            m_rwz_reg <= m_rwz_next;
            m_rxy_reg <= m_rxy_next;
            m_ryx_reg <= m_ryx_next;
            op3_reg   <= op2_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: vector part of r * conj(q) or r * q, rounded to Q16.16
    // ------------------------------------------------------------------
    logic signed [SUM2_W-1:0] tx, ty, tz, sox, soy, soz;
    logic signed [O_W-1:0]    o_x_reg, o_y_reg, o_z_reg;
    logic signed [O_W-1:0]    o_x_next, o_y_next, o_z_next;

    always_comb
    begin
        tx  = SUM2_W'(m_rwx_reg) + SUM2_W'(m_ryz_reg) - SUM2_W'(m_rzy_reg);
        ty  = SUM2_W'(m_rwy_reg) + SUM2_W'(m_rzx_reg) - SUM2_W'(m_rxz_reg);
        tz  = SUM2_W'(m_rwz_reg) + SUM2_W'(m_rxy_reg) - SUM2_W'(m_ryx_reg);
        sox = SUM2_W'(m_rxw_reg) + ((op3_reg == OP_INV) ? tx : -tx);
        soy = SUM2_W'(m_ryw_reg) + ((op3_reg == OP_INV) ? ty : -ty);
        soz = SUM2_W'(m_rzw_reg) + ((op3_reg == OP_INV) ? tz : -tz);
        o_x_next = O_W'((sox + RND2) >>> ROUND_SH);
        o_y_next = O_W'((soy + RND2) >>> ROUND_SH);
        o_z_next = O_W'((soz + RND2) >>> ROUND_SH);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_OPRE])
        begin
            o_x_reg <= o_x_next;
            o_y_reg <= o_y_next;
            o_z_reg <= o_z_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 5: saturate to 32 bits and hold the output word
    // ------------------------------------------------------------------
    // returns {saturated, value}
    function automatic logic [V_W:0] sat_q16(input logic signed [O_W-1:0] v);
        logic hi_bits_same;
        logic [V_W-1:0] res;
        hi_bits_same = (v[O_W-1:V_W-1] == '0) || (v[O_W-1:V_W-1] == '1);
        if (hi_bits_same)
        begin
            res = v[V_W-1:0];
        end
        else if (v[O_W-1])
        begin
            res = {1'b1, {(V_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(V_W-1){1'b1}}};
        end
        return {!hi_bits_same, res};
    endfunction

    logic [V_W:0] sat_x, sat_y, sat_z;
    rsp_t         out_reg;
    rsp_t         out_next;

    always_comb
    begin
        sat_x             = sat_q16(o_x_reg);
        sat_y             = sat_q16(o_y_reg);
        sat_z             = sat_q16(o_z_reg);
        out_next.out_x    = sat_x[V_W-1:0];
        out_next.out_y    = sat_y[V_W-1:0];
        out_next.out_z    = sat_z[V_W-1:0];
        out_next.overflow = sat_x[V_W] | sat_y[V_W] | sat_z[V_W];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[ST_OUT])
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = ctl.valid[ST_OUT];
    assign rsp       = out_reg;

endmodule

@@ tb/sv/rotation_checker.sv @@
// ----------------------------------------------------------------------------
// rotation_checker
// Watches both channels of the quaternion vector rotation block, computes the
// rotated vector for every accepted request word and compares it field by
// field with the response words in order of arrival.
// ----------------------------------------------------------------------------
module rotation_checker
    import qrv_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   mismatches,
    output int   outstanding
);

    // wide enough for every exact sum of products
    typedef logic signed [127:0] wide_t;

    localparam wide_t V_MAX = (wide_t'(1) <<< (V_W - 1)) - 1;
    localparam wide_t V_MIN = -(wide_t'(1) <<< (V_W - 1));

    rsp_t rotated_q[$];
    int   fails = 0;
    int   words_seen = 0;

    // round half up, then drop the Q2.30 fraction
    function automatic wide_t round_q30(input wide_t acc);
        return (acc + (wide_t'(1) <<< (ROUND_SH - 1))) >>> ROUND_SH;
    endfunction

    // expected rotated vector for one request word
    function automatic rsp_t rotate_expected(input req_t d);
        wide_t sg, w, x, y, z, px, py, pz;
        wide_t rw, rx, ry, rz;
        wide_t o[3];
        rsp_t  r;
        sg = (d.op == OP_INV) ? -wide_t'(1) : wide_t'(1);
        w  = wide_t'(d.quat_w);
        x  = wide_t'(d.quat_x);
        y  = wide_t'(d.quat_y);
        z  = wide_t'(d.quat_z);
        px = wide_t'(d.vec_x);
        py = wide_t'(d.vec_y);
        pz = wide_t'(d.vec_z);
        // intermediate quaternion, product with the pure vector
        rw = round_q30(-sg * (x * px + y * py + z * pz));
        rx = round_q30(w * px + sg * (y * pz - z * py));
        ry = round_q30(w * py + sg * (z * px - x * pz));
        rz = round_q30(w * pz + sg * (x * py - y * px));
        // vector part of the product with the conjugate side
        o[0] = round_q30(rx * w - sg * rw * x - sg * ry * z + sg * rz * y);
        o[1] = round_q30(ry * w - sg * rw * y - sg * rz * x + sg * rx * z);
        o[2] = round_q30(rz * w - sg * rw * z - sg * rx * y + sg * ry * x);
        r.overflow = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (o[i] > V_MAX)
            begin
                o[i] = V_MAX;
                r.overflow = 1'b1;
            end
            else if (o[i] < V_MIN)
            begin
                o[i] = V_MIN;
                r.overflow = 1'b1;
            end
        end
        r.out_x = o[0][V_W-1:0];
        r.out_y = o[1][V_W-1:0];
        r.out_z = o[2][V_W-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            fails++;
            $display("%0t result word %0d %s: expected %h got %h",
                     $time, words_seen, name, want, got);
        end
    endtask

    // compare results against the oldest prediction, queue new predictions
    always @(posedge clk)
    begin : watch
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (rotated_q.size() == 0)
                begin
                    fails++;
                    $display("%0t unexpected result word: expected none got %h",
                             $time, rsp);
                end
                else
                begin
                    want = rotated_q.pop_front();
                    check_field("out_x", want.out_x, rsp.out_x);
                    check_field("out_y", want.out_y, rsp.out_y);
                    check_field("out_z", want.out_z, rsp.out_z);
                    check_field("overflow", {31'b0, want.overflow}, {31'b0, rsp.overflow});
                end
                words_seen++;
            end
            if (req_valid && req_ready)
                rotated_q.push_back(rotate_expected(req));
        end
        mismatches  <= fails;
        outstanding <= rotated_q.size();
    end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random rotation words into quat_rotate_vector with
// random idle and stall phases plus one long receiver hold-off, and reports
// the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module testbench;
    import qrv_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_WORDS  = 370;
    localparam int LONG_HOLD    = 160;
    localparam int DRAIN_CYCLES = 12;

    localparam int S_MAX = 2147483647;
    localparam int S_MIN = -2147483647 - 1;
    localparam int Q_ONE = 1073741824;    // 1.0 in Q2.30
    localparam int C45   = 759250125;     // cos 45 deg in Q2.30
    localparam int V_ONE = 65536;         // 1.0 in Q16.16

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready;
    rsp_t rsp;

    int mismatches;
    int outstanding;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int holds_done = 0;
    int cycles = 0;

    quat_rotate_vector i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    rotation_checker i_rotation_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        int n;
        rsp_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_done)
            begin
                rsp_ready <= 1'b0;
                for (n = 0; n < LONG_HOLD; n++)
                    @(posedge clk);
                holds_done++;
            end
            rsp_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic req_t make_word(input logic op, input int w, input int x,
                                       input int y, input int z, input int vx,
                                       input int vy, input int vz);
        req_t d;
        d.op     = op;
        d.quat_w = w;
        d.quat_x = x;
        d.quat_y = y;
        d.quat_z = z;
        d.vec_x  = vx;
        d.vec_y  = vy;
        d.vec_z  = vz;
        return d;
    endfunction

    // signed value spread over the low bits only
    function automatic logic signed [31:0] rand_vec(input int bits);
        return $signed($urandom()) >>> (32 - bits);
    endfunction

    function automatic logic signed [31:0] corner_value();
        case ($urandom_range(7))
            0: return 0;
            1: return 1;
            2: return -1;
            3: return S_MAX;
            4: return S_MIN;
            5: return Q_ONE;
            6: return -Q_ONE;
            default: return $urandom();
        endcase
    endfunction

    // normalized rotation with a vector of random magnitude
    function automatic req_t unit_rotation();
        real  c[4];
        real  n;
        int   bits;
        req_t d;
        n = 0.0;
        for (int k = 0; k < 4; k++)
        begin
            c[k] = real'($urandom_range(2000000)) / 1000000.0 - 1.0;
            n += c[k] * c[k];
        end
        if (n < 1.0e-6)
        begin
            c[0] = 1.0;
            n = 1.0;
        end
        n = $sqrt(n);
        bits = $urandom_range(31, 8);
        d.op     = 1'($urandom_range(1));
        d.quat_w = $rtoi(c[0] / n * 1073741823.0);
        d.quat_x = $rtoi(c[1] / n * 1073741823.0);
        d.quat_y = $rtoi(c[2] / n * 1073741823.0);
        d.quat_z = $rtoi(c[3] / n * 1073741823.0);
        d.vec_x  = rand_vec(bits);
        d.vec_y  = rand_vec(bits);
        d.vec_z  = rand_vec(bits);
        return d;
    endfunction

    function automatic req_t random_word();
        req_t d;
        int   kind;
        kind = $urandom_range(99);
        if (kind < 50)
            d = unit_rotation();
        else if (kind < 90)
        begin
            // raw quaternion, full range or small vector
            d.op     = 1'($urandom_range(1));
            d.quat_w = $urandom();
            d.quat_x = $urandom();
            d.quat_y = $urandom();
            d.quat_z = $urandom();
            if (kind < 70)
            begin
                d.vec_x = rand_vec(18);
                d.vec_y = rand_vec(18);
                d.vec_z = rand_vec(18);
            end
            else
            begin
                d.vec_x = $urandom();
                d.vec_y = $urandom();
                d.vec_z = $urandom();
            end
        end
        else
            d = make_word(1'($urandom_range(1)), corner_value(), corner_value(),
                          corner_value(), corner_value(), corner_value(),
                          corner_value(), corner_value());
        return d;
    endfunction

    // offer one word, with random idle cycles ahead of it
    task automatic send_word(input req_t w);
        while ($urandom_range(99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req       <= w;
        req_valid <= 1'b1;
        do @(posedge clk); while (req_ready !== 1'b1);
    endtask

    task automatic set_mode(input int gap, input int stall);
        gap_pct = gap;
        stall_pct <= stall;
    endtask

    // stimulus and verdict
    initial
    begin
        logic op;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed words, each in both directions
        set_mode(0, 0);
        for (int k = 0; k < 2; k++)
        begin
            op = (k == 0) ? OP_FWD : OP_INV;
            // identity
            send_word(make_word(op, Q_ONE, 0, 0, 0, V_ONE, -2 * V_ONE, 3 * V_ONE));
            // quarter turn about z
            send_word(make_word(op, C45, 0, 0, C45, V_ONE, 0, 0));
            // half turn about x
            send_word(make_word(op, 0, Q_ONE, 0, 0, V_ONE, V_ONE, V_ONE));
            // zero quaternion
            send_word(make_word(op, 0, 0, 0, 0, S_MAX, S_MIN, 1));
            // all fields at their maximum
            send_word(make_word(op, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX, S_MAX));
            // all fields at their minimum
            send_word(make_word(op, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN, S_MIN));
            // exact half steps in both rounding passes
            send_word(make_word(op, Q_ONE / 2, 0, 0, 0, 1, -1, 3));
            // overflow on two components, opposite signs
            send_word(make_word(op, S_MAX, 0, 0, 0, Q_ONE, 1, -Q_ONE));
            // overflow on one component only
            send_word(make_word(op, S_MAX, 0, 0, 0, S_MAX, 0, 0));
            // mixed extremes
            send_word(make_word(op, S_MIN, S_MAX, S_MIN, S_MAX, S_MIN, S_MAX, 0));
        end

        // random phases
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: set_mode(0, 0);
                1: set_mode(67, 0);
                2: set_mode(0, 67);
                3: set_mode(24, 24);
                default:
                begin
                    // back pressure: receiver holds off while words keep coming
                    set_mode(0, 0);
                    hold_reqs <= hold_reqs + 1;
                end
            endcase
            repeat (PHASE_WORDS) send_word(random_word());
        end
        req_valid <= 1'b0;

        // drain
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
